@@ design/lbm_pkg.sv @@
// Package for the load balance monitor: sizes, register map, item types.
// No dependencies; imported by every design file.
`default_nettype none

package lbm_pkg;

  localparam int NUM_SERVERS = 16;
  localparam int ACC_WIDTH   = 48;

  localparam int SRV_IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SC_W      = 5;
  localparam int IDX_W     = 8;
  localparam int BYTES_W   = 32;
  localparam int CNT16_W   = 16;
  localparam int RATIO_W   = 17;
  localparam int FRAC_W    = 8;
  localparam int MUL_B_W   = RATIO_W;
  localparam int MUL_P_W   = ACC_WIDTH + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SERVERS = 3'd4;

  localparam logic [CNT16_W-1:0] LIMIT_RST   = 16'd100;
  localparam logic [CNT16_W-1:0] DEGREE_RST  = 16'd512;
  localparam logic [RATIO_W-1:0] RATIO_RST   = 17'd39322;
  localparam logic [SC_W-1:0]    SERVERS_RST = 5'd16;

  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_BATCH = 1'b1;

  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   server_index;
    logic [BYTES_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic               index_error;
    logic               batch_checked;
    logic               batch_unbalanced;
    logic               verdict_ready;
    logic               verdict_failed;
    logic [CNT16_W-1:0] unbalanced_total;
    logic [CNT16_W-1:0] batches_done;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/lbm_acc_file.sv @@
// Per-destination byte accumulators: one write port, one read port, clear-all.
// Depends on lbm_pkg.
`default_nettype none

module lbm_acc_file
  import lbm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire logic                 we,
  input  wire logic [SRV_IDX_W-1:0] waddr,
  input  wire logic [ACC_WIDTH-1:0] wdata,
  input  wire logic [SRV_IDX_W-1:0] raddr,
  output logic      [ACC_WIDTH-1:0] rdata
);

  logic [ACC_WIDTH-1:0] acc_r [NUM_SERVERS];

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int k = 0; k < NUM_SERVERS; k++) acc_r[k] <= '0;
    end else if (we) begin
      acc_r[waddr] <= wdata;
    end
  end

  assign rdata = acc_r[raddr];

endmodule

`default_nettype wire

@@ design/lbm_div.sv @@
// Restoring divider, one quotient bit per cycle: total bytes / server count.
// Depends on lbm_pkg.
`default_nettype none

module lbm_div
  import lbm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [ACC_WIDTH-1:0] dividend,
  input  wire logic [SC_W-1:0]      divisor,
  output logic                      done,
  output logic      [ACC_WIDTH-1:0] quotient
);

  localparam int STEP_W = $clog2(ACC_WIDTH + 1);

  logic [ACC_WIDTH-1:0] quo_r;
  logic [SC_W-1:0]      rem_r;
  logic [SC_W-1:0]      dvs_r;
  logic [STEP_W-1:0]    cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [SC_W:0]        trial;
  logic                 fits;

  assign trial = {rem_r, quo_r[ACC_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= STEP_W'(ACC_WIDTH);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[ACC_WIDTH-2:0], fits};
      rem_r <= fits ? SC_W'(trial - {1'b0, dvs_r}) : trial[SC_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ design/lbm_mul.sv @@
// Shared registered multiplier for the degree, per-destination and verdict products.
// Depends on lbm_pkg.
`default_nettype none

module lbm_mul
  import lbm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [ACC_WIDTH-1:0] a,
  input  wire logic [MUL_B_W-1:0]   b,
  output logic      [MUL_P_W-1:0]   p
);

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ design/load_balance_monitor_top.sv @@
// Load balance monitor top level: sequencer, configuration registers, output register.
// Depends on lbm_pkg, lbm_acc_file, lbm_div, lbm_mul.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries probes and end-of-batch
//   commands; every item produces exactly one result on the output channel
//   (out_valid / out_stall / out_data). The configuration port (cfg_valid /
//   cfg_ready / cfg_index / cfg_data) is always ready; write it only while idle.
//   Items are handled one at a time; in_stall is high while an item is in work.
//   A probe, or a skipped check, goes from its execute state straight to the output state.
//   An end-of-batch check runs the bit-serial average divider, then uses the shared
//   multiplier for the degree bound and for each destination visited, at most n and
//   stopping at the first unbalanced one, and once more when a verdict is due.
//   A finished result sits in the output register while the next item is taken;
//   with out_stall high the sequencer holds the next result until the slot frees.
//   Reset (rst_n low, synchronous) clears all accumulators, counts, the state, out_valid
//   and the configuration registers; datapath holding registers and out_data are not reset.
`default_nettype none

module load_balance_monitor_top
  import lbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_MDEG  = 4'd3;
  localparam logic [3:0] S_MDEGW = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_VERD  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic               en_r;
  logic [CNT16_W-1:0] limit_r;
  logic [CNT16_W-1:0] degree_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [SC_W-1:0]    servers_r;

  in_item_t             item_r;
  logic [ACC_WIDTH-1:0] total_r;
  logic [CNT16_W-1:0]   batches_r;
  logic [CNT16_W-1:0]   unb_r;
  logic [SRV_IDX_W-1:0] i_r;
  logic [ACC_WIDTH-1:0] avg_r;
  logic [MUL_P_W-1:0]   dmax_r;
  logic [ACC_WIDTH-1:0] acc_cur_r;
  logic                 err_r, chk_r, unbal_r, rdy_r, fail_r;

  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [SC_W-1:0]      n_eff;
  logic                 in_xfer;
  logic                 slot_free;
  logic                 idx_bad;
  logic [SRV_IDX_W-1:0] probe_idx;
  logic [ACC_WIDTH-1:0] acc_rdata;
  logic [ACC_WIDTH:0]   acc_sum, tot_sum;
  logic [ACC_WIDTH-1:0] acc_sat, tot_sat;
  logic                 acc_we, acc_clr;
  logic [SRV_IDX_W-1:0] acc_raddr;
  logic                 div_start, div_done;
  logic [ACC_WIDTH-1:0] div_q;
  logic [ACC_WIDTH-1:0] mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic                 unb_hit;
  logic                 last_srv;
  logic [CNT16_W-1:0]   batches_inc;

  always_comb begin
    if (servers_r == '0) begin
      n_eff = SC_W'(1);
    end else if (int'(servers_r) > NUM_SERVERS) begin
      n_eff = SC_W'(NUM_SERVERS);
    end else begin
      n_eff = servers_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign probe_idx = SRV_IDX_W'(item_r.server_index);
  assign idx_bad   = ({1'b0, item_r.server_index} >= (IDX_W + 1)'(n_eff));
  assign acc_raddr = (state_r == S_EXEC) ? probe_idx : i_r;

  assign acc_sum = {1'b0, acc_rdata} + (ACC_WIDTH + 1)'(item_r.byte_count);
  assign tot_sum = {1'b0, total_r} + (ACC_WIDTH + 1)'(item_r.byte_count);
  assign acc_sat = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];
  assign tot_sat = tot_sum[ACC_WIDTH] ? '1 : tot_sum[ACC_WIDTH-1:0];

  assign batches_inc = batches_r + 1'b1;
  assign last_srv    = ((int'(i_r) + 1) == int'(n_eff));
  assign unb_hit     = (MUL_P_W'({acc_cur_r, FRAC_W'(0)}) > dmax_r) ||
                       (MUL_P_W'({avg_r, FRAC_W'(0)}) > mul_p);

  always_comb begin
    unique case (state_r)
      S_MDEG:  begin
        mul_a = avg_r;
        mul_b = MUL_B_W'(degree_r);
      end
      S_UPD:   begin
        mul_a = ACC_WIDTH'(batches_inc);
        mul_b = ratio_r;
      end
      default: begin
        mul_a = acc_rdata;
        mul_b = MUL_B_W'(degree_r);
      end
    endcase
  end

  assign acc_we    = (state_r == S_EXEC) && (item_r.command == CMD_PROBE) && en_r &&
                     (batches_r <= limit_r) && !idx_bad;
  assign acc_clr   = (state_r == S_UPD);
  assign div_start = (state_r == S_EXEC) && (item_r.command == CMD_BATCH) && en_r &&
                     (batches_r < limit_r) && (total_r != '0);

  lbm_acc_file u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (acc_clr),
    .we    (acc_we),
    .waddr (probe_idx),
    .wdata (acc_sat),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  lbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  lbm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = div_start ? S_DIV : S_OUT;
      S_DIV:   if (div_done) state_nxt = S_MDEG;
      S_MDEG:  state_nxt = S_MDEGW;
      S_MDEGW: state_nxt = S_RD;
      S_RD:    state_nxt = S_CMP;
      S_CMP:   state_nxt = (unb_hit || last_srv) ? S_UPD : S_RD;
      S_UPD:   state_nxt = (batches_inc == limit_r) ? S_VERD : S_OUT;
      S_VERD:  state_nxt = S_OUT;
      S_OUT:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      en_r      <= 1'b0;
      limit_r   <= LIMIT_RST;
      degree_r  <= DEGREE_RST;
      ratio_r   <= RATIO_RST;
      servers_r <= SERVERS_RST;
      total_r   <= '0;
      batches_r <= '0;
      unb_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ENABLE:  en_r      <= cfg_data[0];
          REG_LIMIT:   limit_r   <= cfg_data[CNT16_W-1:0];
          REG_DEGREE:  degree_r  <= cfg_data[CNT16_W-1:0];
          REG_RATIO:   ratio_r   <= cfg_data[RATIO_W-1:0];
          REG_SERVERS: servers_r <= cfg_data[SC_W-1:0];
          default:     ;
        endcase
      end
      if (acc_we) total_r <= tot_sat;
      if (state_r == S_UPD) begin
        total_r   <= '0;
        batches_r <= batches_inc;
        if (unbal_r && (unb_r != '1)) unb_r <= unb_r + 1'b1;
      end
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r  <= in_data;
      err_r   <= 1'b0;
      chk_r   <= 1'b0;
      unbal_r <= 1'b0;
      rdy_r   <= 1'b0;
      fail_r  <= 1'b0;
    end
    if (state_r == S_EXEC) begin
      err_r <= (item_r.command == CMD_PROBE) && en_r && (batches_r <= limit_r) && idx_bad;
      chk_r <= div_start;
      i_r   <= '0;
    end
    if (div_done) avg_r <= div_q;
    if (state_r == S_MDEGW) dmax_r <= mul_p;
    if (state_r == S_RD) acc_cur_r <= acc_rdata;
    if (state_r == S_CMP) begin
      if (unb_hit) unbal_r <= 1'b1;
      if (!unb_hit && !last_srv) i_r <= i_r + 1'b1;
    end
    if (state_r == S_UPD) rdy_r <= (batches_inc == limit_r);
    if (state_r == S_VERD) fail_r <= (MUL_P_W'({unb_r, 16'h0000}) > mul_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && slot_free) begin
      out_data_r.index_error      <= err_r;
      out_data_r.batch_checked    <= chk_r;
      out_data_r.batch_unbalanced <= unbal_r;
      out_data_r.verdict_ready    <= rdy_r;
      out_data_r.verdict_failed   <= fail_r;
      out_data_r.unbalanced_total <= unb_r;
      out_data_r.batches_done     <= batches_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/lbm_checker.sv @@
// Port-level checks for load_balance_monitor_top, attached by bind.
// Depends on lbm_pkg and the top level's port list.
`default_nettype none

module lbm_checker
  import lbm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  a_checked_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.batch_checked) |-> (out_data.batches_done != '0))
    else $error("checked batch without batch count");

  a_verdict_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.verdict_ready) |-> out_data.batch_checked)
    else $error("verdict without a batch check");

  a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.index_error) |->
      (!out_data.batch_checked && !out_data.batch_unbalanced))
    else $error("index error on a batch check");

endmodule

bind load_balance_monitor_top lbm_checker u_lbm_checker (.*);

`default_nettype wire
